[hdl/kwsc_pkg.sv]
// Shared types, constants and letter decode for the keyword substitution cipher.
package kwsc_pkg;

    localparam int LETTERS = 26;
    localparam int IDX_W   = 5;

    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LETTERS - 1);
    localparam logic [IDX_W-1:0] TABLE_LEN = IDX_W'(LETTERS);

    typedef enum logic [1:0] {
        MODE_KEY  = 2'd0,
        MODE_SEAL = 2'd1,
        MODE_ENC  = 2'd2,
        MODE_DEC  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEAL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             is_letter;
        logic             upper;
        logic [IDX_W-1:0] idx;
    } letter_t;

    typedef struct packed {
        logic             fwd_we;
        logic [IDX_W-1:0] fwd_addr;
        logic [IDX_W-1:0] fwd_data;
        logic             inv_we;
        logic [IDX_W-1:0] inv_addr;
        logic [IDX_W-1:0] inv_data;
        logic             rd_en;
        logic             rd_inv;
        logic [IDX_W-1:0] rd_addr;
    } tbl_req_t;

    function automatic letter_t decode_letter(input logic [7:0] c);
        letter_t r;
        r = '0;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r.is_letter = 1'b1;
            r.idx       = IDX_W'(c - LOWER_A);
        end
        else if (c >= UPPER_A && c <= UPPER_Z)
        begin
            r.is_letter = 1'b1;
            r.upper     = 1'b1;
            r.idx       = IDX_W'(c - UPPER_A);
        end
        return r;
    endfunction

endpackage

[hdl/kwsc_tables.sv]
// Forward and inverse substitution tables with one write port each and a registered read.
module kwsc_tables (
    input  logic                         clk,
    input  kwsc_pkg::tbl_req_t           req,
    output logic [kwsc_pkg::IDX_W-1:0]   rdata
);

    logic [kwsc_pkg::IDX_W-1:0] fwd_mem [kwsc_pkg::LETTERS];
    logic [kwsc_pkg::IDX_W-1:0] inv_mem [kwsc_pkg::LETTERS];
    logic [kwsc_pkg::IDX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.fwd_we)
        begin
            fwd_mem[req.fwd_addr] <= req.fwd_data;
        end
        if (req.inv_we)
        begin
            inv_mem[req.inv_addr] <= req.inv_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= req.rd_inv ? inv_mem[req.rd_addr] : fwd_mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/kwsc_ctrl.sv]
// Sequencer: key append, seal walk over the alphabet, and table lookup for text bytes.
module kwsc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [7:0]                   char_in,
    output kwsc_pkg::tbl_req_t           req,
    input  logic [kwsc_pkg::IDX_W-1:0]   rdata,
    output logic                         res_valid,
    output logic [7:0]                   res_char,
    input  logic                         res_ready
);

    kwsc_pkg::state_t            state_reg, state_next;
    logic [kwsc_pkg::LETTERS-1:0] present_reg, present_next;
    logic [kwsc_pkg::IDX_W-1:0]  len_reg, len_next;
    logic [kwsc_pkg::IDX_W-1:0]  walk_reg, walk_next;
    logic                        sealed_reg, sealed_next;
    logic [7:0]                  char_reg, char_next;
    logic                        letter_reg, letter_next;
    logic                        upper_reg, upper_next;

    kwsc_pkg::letter_t           in_letter;
    logic [kwsc_pkg::IDX_W-1:0]  walk_idx;
    logic                        accept;

    assign in_letter = kwsc_pkg::decode_letter(char_in);
    assign walk_idx  = kwsc_pkg::LAST_IDX - walk_reg;
    assign in_stall  = (state_reg != kwsc_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kwsc_pkg::ST_IDLE;
            present_reg <= '0;
            len_reg     <= '0;
            walk_reg    <= '0;
            sealed_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            len_reg     <= len_next;
            walk_reg    <= walk_next;
            sealed_reg  <= sealed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        letter_reg <= letter_next;
        upper_reg  <= upper_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        present_next = present_reg;
        len_next     = len_reg;
        walk_next    = walk_reg;
        sealed_next  = sealed_reg;
        char_next    = char_reg;
        letter_next  = letter_reg;
        upper_next   = upper_reg;
        req          = '0;
        res_valid    = 1'b0;
        res_char     = char_reg;

        unique case (state_reg)
            kwsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kwsc_pkg::mode_t'(mode))
                        kwsc_pkg::MODE_KEY:
                        begin
                            if (!sealed_reg && in_letter.is_letter
                                && len_reg < kwsc_pkg::TABLE_LEN
                                && !present_reg[in_letter.idx])
                            begin
                                req.fwd_we   = 1'b1;
                                req.fwd_addr = len_reg;
                                req.fwd_data = in_letter.idx;
                                req.inv_we   = 1'b1;
                                req.inv_addr = in_letter.idx;
                                req.inv_data = len_reg;
                                present_next[in_letter.idx] = 1'b1;
                                len_next     = len_reg + 1'b1;
                            end
                        end
                        kwsc_pkg::MODE_SEAL:
                        begin
                            if (!sealed_reg)
                            begin
                                walk_next  = '0;
                                state_next = kwsc_pkg::ST_SEAL;
                            end
                        end
                        kwsc_pkg::MODE_ENC,
                        kwsc_pkg::MODE_DEC:
                        begin
                            char_next   = char_in;
                            letter_next = in_letter.is_letter;
                            upper_next  = in_letter.upper;
                            req.rd_en   = in_letter.is_letter;
                            req.rd_inv  = (kwsc_pkg::mode_t'(mode) == kwsc_pkg::MODE_DEC);
                            req.rd_addr = in_letter.idx;
                            state_next  = kwsc_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            kwsc_pkg::ST_SEAL:
            begin
                // place each absent letter, z first, after the key
                if (!present_reg[walk_idx])
                begin
                    req.fwd_we   = 1'b1;
                    req.fwd_addr = len_reg;
                    req.fwd_data = walk_idx;
                    req.inv_we   = 1'b1;
                    req.inv_addr = walk_idx;
                    req.inv_data = len_reg;
                    present_next[walk_idx] = 1'b1;
                    len_next     = len_reg + 1'b1;
                end
                walk_next = walk_reg + 1'b1;
                if (walk_reg == kwsc_pkg::LAST_IDX)
                begin
                    sealed_next = 1'b1;
                    state_next  = kwsc_pkg::ST_IDLE;
                end
            end
            kwsc_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
                if (letter_reg)
                begin
                    res_char = (upper_reg ? kwsc_pkg::UPPER_A : kwsc_pkg::LOWER_A)
                               + {3'b000, rdata};
                end
                if (res_ready)
                begin
                    state_next = kwsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kwsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/keyword_substitution_cipher.sv]
// Top level of the keyword substitution cipher: sequencer, tables and output register.
//
// Input channel (in_valid/in_stall, fields mode and char_in) takes one command per
// transfer: mode 0 appends a key letter, mode 1 seals the table, mode 2 encodes and
// mode 3 decodes one byte. Only modes 2 and 3 give a result on the output channel
// (out_valid/out_stall, field char_out); letter case is kept, non-letters pass as is.
// Key letter: no result, and the input is not held. Seal: one alphabet entry per cycle
// through the shared walk counter, with both tables written in the same step.
// Encode/decode: the table read and the output register are both registered, so a byte
// reaches char_out after both; the next command waits until it enters the output register.
// in_stall is high while a seal walk or a lookup is in progress.
// The output register holds a finished result while the next command is taken;
// if the receiver keeps out_stall high, a new result waits inside and in_stall
// stays high until the register drains.
// Reset clears key length, letter mask, seal flag and the output valid; the
// tables themselves are not cleared and are only defined once sealed.
module keyword_substitution_cipher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out
);

    kwsc_pkg::tbl_req_t         req;
    logic [kwsc_pkg::IDX_W-1:0] rdata;
    logic                       res_valid;
    logic [7:0]                 res_char;
    logic                       out_free;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 char_out_reg, char_out_next;

    kwsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .char_in   (char_in),
        .req       (req),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res_char  (res_char),
        .res_ready (out_free)
    );

    kwsc_tables u_tables (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_out_next  = char_out_reg;
        if (out_free)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                char_out_next = res_char;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_out_reg <= char_out_next;
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;

endmodule

[hdl/kwsc_checker.sv]
// Port checker for the keyword substitution cipher and its bind to the top level.
module kwsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] mode,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] char_out
);

    logic in_xfer;
    assign in_xfer = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(char_out))
        else $error("result changed while stalled");

    a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (mode == kwsc_pkg::MODE_ENC || mode == kwsc_pkg::MODE_DEC) |=> in_stall)
        else $error("text transfer did not hold the input");

    a_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && mode == kwsc_pkg::MODE_KEY |=> !in_stall)
        else $error("key letter transfer held the input");

endmodule

bind keyword_substitution_cipher kwsc_checker u_kwsc_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the keyword substitution cipher: key, seal, then text traffic.
module testbench;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int TEXT_ITEMS   = 2000;
    localparam int PRESSURE_AT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    class cipher_scoreboard;
        logic [kwsc_pkg::IDX_W-1:0] fwd_map [kwsc_pkg::LETTERS];
        logic [kwsc_pkg::IDX_W-1:0] inv_map [kwsc_pkg::LETTERS];
        logic [kwsc_pkg::LETTERS-1:0] used_letters;
        int unsigned key_len;
        bit sealed;
        logic [7:0] expected_bytes [$];
        int errors;

        function new();
            used_letters = '0;
            key_len      = 0;
            sealed       = 1'b0;
            errors       = 0;
            foreach (fwd_map[i])
            begin
                fwd_map[i] = '0;
                inv_map[i] = '0;
            end
        endfunction

        function void note_input(kwsc_pkg::mode_t m, logic [7:0] c);
            bit is_let;
            bit up;
            int idx;
            int pos;
            int k;
            logic [7:0] base;
            is_let = 1'b0;
            up     = 1'b0;
            idx    = 0;
            if (c >= kwsc_pkg::LOWER_A && c <= kwsc_pkg::LOWER_Z)
            begin
                is_let = 1'b1;
                idx    = c - kwsc_pkg::LOWER_A;
            end
            else if (c >= kwsc_pkg::UPPER_A && c <= kwsc_pkg::UPPER_Z)
            begin
                is_let = 1'b1;
                up     = 1'b1;
                idx    = c - kwsc_pkg::UPPER_A;
            end
            case (m)
                kwsc_pkg::MODE_KEY:
                begin
                    if (!sealed && is_let && key_len < kwsc_pkg::LETTERS
                        && !used_letters[idx])
                    begin
                        fwd_map[key_len] = kwsc_pkg::IDX_W'(idx);
                        key_len++;
                        used_letters[idx] = 1'b1;
                    end
                end
                kwsc_pkg::MODE_SEAL:
                begin
                    if (!sealed)
                    begin
                        pos = key_len;
                        for (k = kwsc_pkg::LETTERS - 1; k >= 0; k--)
                        begin
                            if (!used_letters[k] && pos < kwsc_pkg::LETTERS)
                            begin
                                fwd_map[pos] = kwsc_pkg::IDX_W'(k);
                                pos++;
                                used_letters[k] = 1'b1;
                            end
                        end
                        for (k = 0; k < kwsc_pkg::LETTERS; k++)
                            inv_map[fwd_map[k]] = kwsc_pkg::IDX_W'(k);
                        sealed = 1'b1;
                    end
                end
                default:
                begin
                    if (!is_let)
                        expected_bytes.push_back(c);
                    else
                    begin
                        base = up ? kwsc_pkg::UPPER_A : kwsc_pkg::LOWER_A;
                        if (m == kwsc_pkg::MODE_ENC)
                            expected_bytes.push_back(base + 8'(fwd_map[idx]));
                        else
                            expected_bytes.push_back(base + 8'(inv_map[idx]));
                    end
                end
            endcase
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] exp_byte;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected char_out, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_byte = expected_bytes.pop_front();
                if (got !== exp_byte)
                begin
                    $display("%0t: char_out expected %h, actual %h", $time, exp_byte, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] mode;
    logic [7:0] char_in;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] char_out;

    cipher_scoreboard book;
    int burst_left;
    int stall_pct;
    int stall_hold;
    int cycle_count = 0;
    int text_count;

    keyword_substitution_cipher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_result(char_out);
        if (stall_hold == 0)
        begin
            stall_hold <= $urandom_range(16, 200);
            case ($urandom_range(0, 2))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                default: stall_pct <= 85;
            endcase
        end
        else
            stall_hold <= stall_hold - 1;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? kwsc_pkg::UPPER_A : kwsc_pkg::LOWER_A;
        return base + 8'($urandom_range(0, kwsc_pkg::LETTERS - 1));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input kwsc_pkg::mode_t m, input logic [7:0] c);
        pace();
        in_valid <= 1'b1;
        mode     <= m;
        char_in  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_input(m, c);
        if (m == kwsc_pkg::MODE_ENC || m == kwsc_pkg::MODE_DEC)
            text_count++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] key_seed [10];
        logic [7:0] text_seed [8];
        int order [kwsc_pkg::LETTERS];
        int n;
        int j;
        int tmp;
        int r;
        bit pressed;

        book       = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = kwsc_pkg::MODE_KEY;
        char_in    = 8'h00;
        out_stall  = 1'b0;
        stall_pct  = 0;
        stall_hold = 0;
        burst_left = 0;
        text_count = 0;
        pressed    = 1'b0;

        key_seed  = '{"Q", "q", "Z", 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, "a"};
        text_seed = '{"a", "Z", 8'h00, 8'hFF, "z", "A", 8'h5B, 8'h7B};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (key_seed[i])
            send_item(kwsc_pkg::MODE_KEY, key_seed[i]);

        n = $urandom_range(0, 40);
        repeat (n)
            send_item(kwsc_pkg::MODE_KEY,
                      ($urandom_range(0, 9) < 7) ? any_letter() : any_byte());

        if ($urandom_range(0, 3) == 0)
        begin
            foreach (order[i])
                order[i] = i;
            for (int i = kwsc_pkg::LETTERS - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            foreach (order[i])
                send_item(kwsc_pkg::MODE_KEY,
                          ($urandom_range(0, 1) ? kwsc_pkg::UPPER_A : kwsc_pkg::LOWER_A)
                          + 8'(order[i]));
        end

        send_item(kwsc_pkg::MODE_SEAL, any_byte());
        send_item(kwsc_pkg::MODE_SEAL, any_byte());
        send_item(kwsc_pkg::MODE_KEY, "b");

        foreach (text_seed[i])
            send_item((i < 4) ? kwsc_pkg::MODE_ENC : kwsc_pkg::MODE_DEC, text_seed[i]);

        while (text_count < TEXT_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(kwsc_pkg::MODE_KEY, any_byte());
            else if (r < 5)
                send_item(kwsc_pkg::MODE_SEAL, any_byte());
            else
                send_item($urandom_range(0, 1) ? kwsc_pkg::MODE_ENC : kwsc_pkg::MODE_DEC,
                          ($urandom_range(0, 9) < 7) ? any_letter() : any_byte());
            if ((!pressed && text_count >= PRESSURE_AT) || $urandom_range(0, 299) == 0)
            begin
                pressed = 1'b1;
                wait_drained();
                burst_left = 0;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[keyword_substitution_cipher.f]
hdl/kwsc_pkg.sv
hdl/kwsc_tables.sv
hdl/kwsc_ctrl.sv
hdl/keyword_substitution_cipher.sv
hdl/kwsc_checker.sv
dv/testbench.sv
